// ----- hw/rtl/rrt_pkg.sv -----
// Shared types, codes and field widths of the register rename table.
package rrt_pkg;

  localparam int unsigned TAG_W  = 7;
  localparam int unsigned REGF_W = 5;
  localparam int unsigned SLOT_W = 6;
  localparam int unsigned FUNC_W = 2;
  localparam int unsigned CLS_W  = 3;

  // item function codes
  localparam logic [FUNC_W-1:0] FUNC_CYCLE    = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_SQ_START = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_SQ_ENTRY = 2'd2;

  // instruction class codes
  localparam logic [CLS_W-1:0] CLASS_BRANCH = 3'd1;
  localparam logic [CLS_W-1:0] CLASS_STORE  = 3'd3;
  localparam logic [CLS_W-1:0] CLASS_HALT   = 3'd5;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              dispatch_ok;
    logic [CLS_W-1:0]  issue_class;
    logic [REGF_W-1:0] dest_reg;
    logic [SLOT_W-1:0] rob_slot;
    logic [REGF_W-1:0] src1_reg;
    logic [REGF_W-1:0] src2_reg;
    logic              commit_ready;
    logic [REGF_W-1:0] commit_dest;
    logic [TAG_W-1:0]  tag_value;
    logic              entry_writes_reg;
  } req_t;

  typedef struct packed {
    logic [TAG_W-1:0] src1_tag;
    logic [TAG_W-1:0] src2_tag;
    logic [TAG_W-1:0] alloc_tag;
    logic             renamed;
  } rsp_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic rd_src;
    logic rd_cmt;
    logic cmt;
    logic iss;
    logic sq_rd;
    logic sq_wr;
    logic rep;
    logic done;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              sweep_last;
  } sts_t;

endpackage

// ----- hw/rtl/rrt_ctrl.sv -----
// Sequencing state machine of the register rename table.
module rrt_ctrl import rrt_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  input  sts_t sts_i,
  output logic busy_o,
  output cmd_t cmd_o
);

  typedef enum logic [8:0] {
    ST_IDLE   = 9'b000000001,
    ST_RD_SRC = 9'b000000010,
    ST_RD_CMT = 9'b000000100,
    ST_CMT    = 9'b000001000,
    ST_ISS    = 9'b000010000,
    ST_SQ_RD  = 9'b000100000,
    ST_SQ_WR  = 9'b001000000,
    ST_REP    = 9'b010000000,
    ST_FIN    = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != ST_IDLE);

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          case (sts_i.func)
            FUNC_CYCLE:    state_d = ST_RD_SRC;
            FUNC_SQ_START: state_d = ST_SQ_RD;
            FUNC_SQ_ENTRY: state_d = ST_REP;
            default:       state_d = ST_FIN;
          endcase
        end
      end
      ST_RD_SRC: begin
        cmd_o.rd_src = 1'b1;
        state_d      = ST_RD_CMT;
      end
      ST_RD_CMT: begin
        cmd_o.rd_cmt = 1'b1;
        state_d      = ST_CMT;
      end
      ST_CMT: begin
        cmd_o.cmt = 1'b1;
        state_d   = ST_ISS;
      end
      ST_ISS: begin
        cmd_o.iss  = 1'b1;
        cmd_o.done = 1'b1;
        state_d    = ST_IDLE;
      end
      ST_SQ_RD: begin
        cmd_o.sq_rd = 1'b1;
        state_d     = ST_SQ_WR;
      end
      ST_SQ_WR: begin
        cmd_o.sq_wr = 1'b1;
        if (sts_i.sweep_last) begin
          cmd_o.done = 1'b1;
          state_d    = ST_IDLE;
        end else begin
          state_d = ST_SQ_RD;
        end
      end
      ST_REP: begin
        cmd_o.rep  = 1'b1;
        cmd_o.done = 1'b1;
        state_d    = ST_IDLE;
      end
      ST_FIN: begin
        cmd_o.done = 1'b1;
        state_d    = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // an accepted beat always leaves idle, and every item ends back in idle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy_o) |=> busy_o)
    else $error("accepted beat did not make the block busy");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.done |=> !busy_o)
    else $error("item finished but block stayed busy");

endmodule

// ----- hw/rtl/rrt_datapath.sv -----
// Alias table storage, repair marks and result registers of the rename table.
module rrt_datapath import rrt_pkg::*; #(
  parameter int unsigned NUM_REGS  = 32,
  parameter int unsigned ROB_DEPTH = 64
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  req_t req_i,
  input  cmd_t cmd_i,
  output sts_t sts_o,
  output logic done_o,
  output rsp_t rsp_o
);

  localparam int unsigned REG_W    = $clog2(NUM_REGS);
  localparam int unsigned SLOT_NUM = 2 ** SLOT_W;

  // true when a register field names an existing register
  function automatic logic in_rng(input logic [REGF_W-1:0] r);
    return TAG_W'(r) < TAG_W'(NUM_REGS);
  endfunction

  req_t             req_q;
  rsp_t             res_q;
  logic             done_q;
  logic [TAG_W-1:0] sq_point_q;
  logic [REG_W-1:0] cnt_q;
  logic [NUM_REGS-1:0] mark_q;
  logic [NUM_REGS-1:0] valid_q;

  logic [TAG_W-1:0] mem [NUM_REGS];
  logic [TAG_W-1:0] rd_a_q, rd_b_q;
  logic             val_a_q, val_b_q;
  logic [REG_W-1:0] addr_a, addr_b, wr_addr;
  logic             rng_a, rng_b, wr_en;
  logic [TAG_W-1:0] wr_data, tag_a, tag_b, new_tag;
  logic             iss_acc, iss_write, com, over, rep_ok;

  // slot wrap table, worked out at elaboration
  logic [SLOT_W-1:0] slot_mod [SLOT_NUM];
  for (genvar i = 0; i < SLOT_NUM; i++) begin : g_slot
    assign slot_mod[i] = SLOT_W'(i % ROB_DEPTH);
  end

  // issue decode
  assign iss_acc   = req_q.dispatch_ok && (req_q.issue_class <= CLASS_HALT);
  assign iss_write = iss_acc && (req_q.dest_reg != '0) && in_rng(req_q.dest_reg)
                     && (req_q.issue_class != CLASS_BRANCH)
                     && (req_q.issue_class != CLASS_STORE);
  assign new_tag   = iss_acc ? (TAG_W'(slot_mod[req_q.rob_slot]) + TAG_W'(1)) : '0;

  // registered read data, zero for unwritten or nonexistent entries
  assign tag_a = val_a_q ? rd_a_q : '0;
  assign tag_b = val_b_q ? rd_b_q : '0;

  // commit clear only if the head still owns the entry and issue does not win
  assign com = req_q.commit_ready && in_rng(req_q.commit_dest)
               && (tag_a == req_q.tag_value)
               && !(iss_write && (req_q.dest_reg == req_q.commit_dest));
  assign over   = tag_a > req_q.tag_value;
  assign rep_ok = req_q.entry_writes_reg && in_rng(req_q.dest_reg)
                  && mark_q[REG_W'(req_q.dest_reg)]
                  && (req_q.tag_value <= sq_point_q);

  // read address selection
  always_comb begin
    addr_a = '0;
    addr_b = REG_W'(req_q.src2_reg);
    rng_a  = 1'b1;
    rng_b  = in_rng(req_q.src2_reg);
    if (cmd_i.rd_src) begin
      addr_a = REG_W'(req_q.src1_reg);
      rng_a  = in_rng(req_q.src1_reg);
    end else if (cmd_i.rd_cmt) begin
      addr_a = REG_W'(req_q.commit_dest);
      rng_a  = in_rng(req_q.commit_dest);
    end else if (cmd_i.sq_rd) begin
      addr_a = cnt_q;
    end
  end

  // write port selection
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = REG_W'(req_q.dest_reg);
    wr_data = '0;
    if (cmd_i.cmt) begin
      wr_en   = com;
      wr_addr = REG_W'(req_q.commit_dest);
    end else if (cmd_i.iss) begin
      wr_en   = iss_write;
      wr_data = new_tag;
    end else if (cmd_i.sq_wr) begin
      wr_en   = over;
      wr_addr = cnt_q;
    end else if (cmd_i.rep) begin
      wr_en   = rep_ok;
      wr_data = req_q.tag_value;
    end
  end

  // table memory
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_a_q  <= mem[addr_a];
    rd_b_q  <= mem[addr_b];
    val_a_q <= valid_q[addr_a] && rng_a;
    val_b_q <= valid_q[addr_b] && rng_b;
  end

  // valid bits, repair marks, squash point, sweep counter, strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      mark_q     <= '0;
      sq_point_q <= '0;
      cnt_q      <= '0;
      done_q     <= 1'b0;
    end else begin
      done_q <= cmd_i.done;
      if (wr_en) begin
        valid_q[wr_addr] <= 1'b1;
      end
      if (cmd_i.load) begin
        cnt_q <= '0;
        if (req_i.func == FUNC_SQ_START) begin
          sq_point_q <= req_i.tag_value;
        end
      end
      if (cmd_i.sq_wr) begin
        mark_q[cnt_q] <= over;
        cnt_q         <= cnt_q + REG_W'(1);
      end
    end
  end

  // item and result registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q <= req_i;
      res_q <= '0;
    end
    if (cmd_i.rd_cmt) begin
      res_q.src1_tag <= tag_a;
      res_q.src2_tag <= tag_b;
    end
    if (cmd_i.iss) begin
      res_q.alloc_tag <= new_tag;
      res_q.renamed   <= iss_write;
    end
    if (cmd_i.rep) begin
      res_q.renamed <= rep_ok;
    end
  end

  assign sts_o.func       = req_i.func;
  assign sts_o.sweep_last = (cnt_q == REG_W'(NUM_REGS - 1));
  assign done_o           = done_q;
  assign rsp_o            = res_q;

  // result strobe is a single-cycle pulse
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q)
    else $error("result strobe held longer than one cycle");

  // only a rename cycle can hand out an issue tag
  a_tag_func: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && (res_q.alloc_tag != '0)) |-> (req_q.func == FUNC_CYCLE))
    else $error("issue tag returned by a squash beat");

endmodule

// ----- hw/rtl/register_rename_table.sv -----
// Register rename table: alias map with commit clear and squash repair.
// A rename/commit beat steps through source read, commit read, commit and issue
// before its strobe; a repair entry takes one repair step and an unused function code
// none; a squash start sweeps the table, one read and one write per entry.
// A new beat is taken in the strobe cycle, never while busy; the steps are set by
// the table's two read ports and single write port. The receiver cannot stall.
// Reset clears the map at once through per-entry valid bits; no clearing pass.
module register_rename_table import rrt_pkg::*; #(
  parameter int unsigned NUM_REGS  = 32,
  parameter int unsigned ROB_DEPTH = 64
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  req_t req_i,
  output logic done_o,
  output rsp_t rsp_o
);

  cmd_t cmd;
  sts_t sts;

  // state machine
  rrt_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .sts_i  (sts),
    .busy_o (busy),
    .cmd_o  (cmd)
  );

  // table and result datapath
  rrt_datapath #(
    .NUM_REGS  (NUM_REGS),
    .ROB_DEPTH (ROB_DEPTH)
  ) u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_i),
    .cmd_i  (cmd),
    .sts_o  (sts),
    .done_o (done_o),
    .rsp_o  (rsp_o)
  );

endmodule

// ----- test/register_rename_table_test.sv -----
// Self-checking testbench for the register rename table: directed rows, then random traffic.
`timescale 1ns / 1ps

module register_rename_table_test;
  import rrt_pkg::*;

  localparam int N_REGS       = 32;
  localparam int ROB_DEPTH    = 64;
  localparam int RANDOM_BEATS = 1250;
  localparam int LIMIT_CYCLES = 400000;
  localparam int MAX_REPAIRS  = 12;

  // class and function codes the package leaves unnamed
  localparam logic [CLS_W-1:0]  CLASS_INT     = 3'd0;
  localparam logic [CLS_W-1:0]  CLASS_LOAD    = 3'd2;
  localparam logic [CLS_W-1:0]  CLASS_LINK    = 3'd4;
  localparam logic [CLS_W-1:0]  CLASS_INVALID = 3'd6;
  localparam logic [CLS_W-1:0]  CLASS_RSVD    = 3'd7;
  localparam logic [FUNC_W-1:0] FUNC_RSVD     = 2'd3;

  typedef logic [TAG_W-1:0] tag_t;

  typedef struct {
    logic hold;
    rsp_t rsp;
  } pin_t;

  typedef struct {
    req_t req;
    logic hold;
    rsp_t rsp;
  } row_t;

  typedef struct {
    logic [REGF_W-1:0] dest;
    tag_t              tag;
    logic              writes;
  } inflight_t;

  logic clk_i;
  logic rst_ni;
  logic start;
  logic busy;
  req_t req;
  logic done_o;
  rsp_t rsp;

  // shadow rename state
  tag_t alias_map [N_REGS];
  logic repair_flag [N_REGS];
  tag_t squash_tag;

  rsp_t tag_expect_q [$];
  pin_t pin_q [$];
  inflight_t inflight_q [$];

  bit burst;
  int err_cnt;
  int accepted_cnt;
  int checked_cnt;
  int rename_cnt;
  int squash_cnt;
  int cycle_cnt;

  register_rename_table #(
    .NUM_REGS (N_REGS),
    .ROB_DEPTH(ROB_DEPTH)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .start (start),
    .busy  (busy),
    .req_i (req),
    .done_o(done_o),
    .rsp_o (rsp)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // watchdog
  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < LIMIT_CYCLES) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt,
             tag_expect_q.size());
    $display("register_rename_table_test: done, errors");
    $finish;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    err_cnt++;
    $display("%0t mismatch %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  // reads first, then commit clear / rename / squash updates
  task automatic predict_rename(input req_t r, output rsp_t o);
    logic take;
    logic wr;
    logic clr;
    tag_t t_new;
    o = '0;
    case (r.func)
      FUNC_SQ_START: begin
        squash_tag = r.tag_value;
        for (int i = 0; i < N_REGS; i++) begin
          repair_flag[i] = alias_map[i] > r.tag_value;
          if (repair_flag[i]) alias_map[i] = '0;
        end
      end
      FUNC_SQ_ENTRY: begin
        if (r.entry_writes_reg && repair_flag[r.dest_reg] && r.tag_value <= squash_tag) begin
          alias_map[r.dest_reg] = r.tag_value;
          o.renamed = 1'b1;
        end
      end
      FUNC_CYCLE: begin
        take  = r.dispatch_ok && (r.issue_class <= CLASS_HALT);
        wr    = take && (r.dest_reg != '0) && (r.issue_class != CLASS_BRANCH)
                && (r.issue_class != CLASS_STORE);
        t_new = take ? tag_t'((int'(r.rob_slot) % ROB_DEPTH) + 1) : '0;
        clr   = r.commit_ready && (alias_map[r.commit_dest] == r.tag_value);
        o.src1_tag  = alias_map[r.src1_reg];
        o.src2_tag  = alias_map[r.src2_reg];
        o.alloc_tag = t_new;
        o.renamed   = wr;
        // issue wins over commit on the same register
        if (wr && r.dest_reg == r.commit_dest) clr = 1'b0;
        if (clr) alias_map[r.commit_dest] = '0;
        if (wr) alias_map[r.dest_reg] = t_new;
      end
      default: ;
    endcase
  endtask

  function automatic req_t cycle_beat(logic iv, logic [CLS_W-1:0] cls,
                                      logic [REGF_W-1:0] dest, logic [SLOT_W-1:0] slot,
                                      logic [REGF_W-1:0] s1, logic [REGF_W-1:0] s2,
                                      logic crdy, logic [REGF_W-1:0] cdest, tag_t tag);
    req_t r;
    r = '0;
    r.func         = FUNC_CYCLE;
    r.dispatch_ok  = iv;
    r.issue_class  = cls;
    r.dest_reg     = dest;
    r.rob_slot     = slot;
    r.src1_reg     = s1;
    r.src2_reg     = s2;
    r.commit_ready = crdy;
    r.commit_dest  = cdest;
    r.tag_value    = tag;
    return r;
  endfunction

  // repair entry; issue and commit fields carry junk the block must ignore
  function automatic req_t repair_beat(logic [REGF_W-1:0] dest, tag_t tag, logic writes);
    logic [63:0] raw;
    req_t r;
    raw = {$urandom(), $urandom()};
    r = raw[$bits(req_t)-1:0];
    r.func             = FUNC_SQ_ENTRY;
    r.dest_reg         = dest;
    r.tag_value        = tag;
    r.entry_writes_reg = writes;
    return r;
  endfunction

  task automatic send_beat(input req_t item, input logic hold, input rsp_t want);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 4);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    pin_q.push_back('{hold, want});
    start <= 1'b1;
    req   <= item;
    do @(posedge clk_i); while (busy !== 1'b0);
  endtask

  // result check, then accept tracking, both on the same edge
  always @(posedge clk_i) begin
    rsp_t want;
    pin_t pin;
    if (rst_ni) begin
      if (done_o) begin
        if (tag_expect_q.size() == 0) begin
          report_mismatch("result with no beat pending", int'(rsp), 0);
        end else begin
          want = tag_expect_q.pop_front();
          checked_cnt++;
          if (want.renamed) rename_cnt++;
          if (rsp.src1_tag !== want.src1_tag)
            report_mismatch("src1_tag", int'(rsp.src1_tag), int'(want.src1_tag));
          if (rsp.src2_tag !== want.src2_tag)
            report_mismatch("src2_tag", int'(rsp.src2_tag), int'(want.src2_tag));
          if (rsp.alloc_tag !== want.alloc_tag)
            report_mismatch("alloc_tag", int'(rsp.alloc_tag), int'(want.alloc_tag));
          if (rsp.renamed !== want.renamed)
            report_mismatch("renamed", int'(rsp.renamed), int'(want.renamed));
        end
      end
      if (start && busy === 1'b0) begin
        pin = pin_q.pop_front();
        predict_rename(req, want);
        if (pin.hold) want = pin.rsp;
        tag_expect_q.push_back(want);
        accepted_cnt++;
        if (req.func == FUNC_SQ_START) squash_cnt++;
      end
    end
  end

  initial begin
    row_t dir_rows [$];
    inflight_t keep_q [$];
    req_t r;
    logic [63:0] raw;
    logic take;
    tag_t sq_tag;
    int rand_beats;
    int next_slot;
    int pick;
    int n;

    rst_ni = 1'b0;
    start  = 1'b0;
    req    = '0;
    burst  = 1'b0;
    err_cnt = 0;
    accepted_cnt = 0;
    checked_cnt = 0;
    rename_cnt = 0;
    squash_cnt = 0;
    squash_tag = '0;
    foreach (alias_map[i]) begin
      alias_map[i]   = '0;
      repair_flag[i] = 1'b0;
    end

    // directed rows; pinned results are read straight off the spec
    dir_rows.push_back('{cycle_beat(1, CLASS_INT, 5, 63, 0, 0, 0, 0, 0), 1'b1,
                         rsp_t'{7'd0, 7'd0, 7'd64, 1'b1}});
    dir_rows.push_back('{cycle_beat(1, CLASS_INT, 6, 0, 5, 31, 0, 0, 0), 1'b0, '0});
    dir_rows.push_back('{cycle_beat(1, CLASS_INT, 0, 10, 0, 0, 0, 0, 0), 1'b1,
                         rsp_t'{7'd0, 7'd0, 7'd11, 1'b0}});
    dir_rows.push_back('{cycle_beat(1, CLASS_BRANCH, 7, 20, 0, 0, 0, 0, 0), 1'b1,
                         rsp_t'{7'd0, 7'd0, 7'd21, 1'b0}});
    dir_rows.push_back('{cycle_beat(1, CLASS_STORE, 8, 21, 0, 0, 0, 0, 0), 1'b1,
                         rsp_t'{7'd0, 7'd0, 7'd22, 1'b0}});
    dir_rows.push_back('{cycle_beat(1, CLASS_LOAD, 9, 30, 0, 0, 0, 0, 0), 1'b1,
                         rsp_t'{7'd0, 7'd0, 7'd31, 1'b1}});
    dir_rows.push_back('{cycle_beat(1, CLASS_LINK, 31, 40, 0, 0, 0, 0, 0), 1'b1,
                         rsp_t'{7'd0, 7'd0, 7'd41, 1'b1}});
    dir_rows.push_back('{cycle_beat(1, CLASS_HALT, 10, 41, 0, 0, 0, 0, 0), 1'b0, '0});
    dir_rows.push_back('{cycle_beat(1, CLASS_INVALID, 11, 5, 0, 0, 0, 0, 0), 1'b1, '0});
    dir_rows.push_back('{cycle_beat(1, CLASS_RSVD, 12, 6, 0, 0, 0, 0, 0), 1'b1, '0});
    dir_rows.push_back('{cycle_beat(0, CLASS_INT, 13, 7, 0, 0, 0, 0, 0), 1'b1, '0});
    // commit with matching tag, then with a stale tag
    dir_rows.push_back('{cycle_beat(0, CLASS_INT, 0, 0, 5, 9, 1, 5, 64), 1'b0, '0});
    dir_rows.push_back('{cycle_beat(0, CLASS_INT, 0, 0, 5, 6, 1, 6, 7), 1'b0, '0});
    // issue and commit on one register
    dir_rows.push_back('{cycle_beat(1, CLASS_INT, 6, 2, 6, 0, 1, 6, 1), 1'b0, '0});
    // unused function code, every field at its maximum
    dir_rows.push_back('{req_t'('1), 1'b1, '0});
    // squash start carrying issue/commit junk
    r = cycle_beat(1, CLASS_INT, 3, 1, 31, 31, 1, 31, 30);
    r.func = FUNC_SQ_START;
    dir_rows.push_back('{r, 1'b1, '0});
    dir_rows.push_back('{repair_beat(9, 20, 1), 1'b0, '0});
    dir_rows.push_back('{repair_beat(9, 25, 1), 1'b0, '0});
    dir_rows.push_back('{repair_beat(31, 31, 1), 1'b0, '0});
    dir_rows.push_back('{repair_beat(10, 12, 0), 1'b0, '0});
    dir_rows.push_back('{repair_beat(6, 3, 1), 1'b0, '0});
    dir_rows.push_back('{cycle_beat(0, CLASS_INT, 0, 0, 9, 10, 0, 0, 0), 1'b0, '0});
    // squash points at both ends of the tag field
    r = '0;
    r.func = FUNC_SQ_START;
    dir_rows.push_back('{r, 1'b1, '0});
    dir_rows.push_back('{repair_beat(9, 0, 1), 1'b0, '0});
    r.tag_value = '1;
    dir_rows.push_back('{r, 1'b1, '0});

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) send_beat(dir_rows[i].req, dir_rows[i].hold, dir_rows[i].rsp);

    // random traffic: in-order slot allocation, commits from the oldest in flight,
    // squash sequences replaying the in-flight list, plus raw noise
    rand_beats = 0;
    next_slot  = 0;
    while (rand_beats < RANDOM_BEATS) begin
      if ($urandom_range(0, 47) == 0) burst = !burst;
      pick = $urandom_range(0, 99);
      if (pick < 5) begin
        if (inflight_q.size() != 0 && $urandom_range(0, 3) != 0)
          sq_tag = inflight_q[$urandom_range(0, inflight_q.size() - 1)].tag;
        else
          sq_tag = tag_t'($urandom_range(0, 127));
        r = '0;
        r.func      = FUNC_SQ_START;
        r.tag_value = sq_tag;
        send_beat(r, 1'b0, '0);
        rand_beats++;
        n = 0;
        foreach (inflight_q[i]) begin
          if (n < MAX_REPAIRS) begin
            send_beat(repair_beat(inflight_q[i].dest, inflight_q[i].tag,
                                  inflight_q[i].writes), 1'b0, '0);
            n++;
            rand_beats++;
          end
        end
        // drop squashed entries, restart allocation after the squash point
        keep_q = {};
        foreach (inflight_q[i])
          if (inflight_q[i].tag <= sq_tag) keep_q.push_back(inflight_q[i]);
        inflight_q = keep_q;
        next_slot = int'(sq_tag) % ROB_DEPTH;
      end else if (pick < 12) begin
        raw = {$urandom(), $urandom()};
        r = raw[$bits(req_t)-1:0];
        send_beat(r, 1'b0, '0);
        if (r.func != FUNC_RSVD) rand_beats++;
      end else begin
        r = '0;
        r.func        = FUNC_CYCLE;
        r.dispatch_ok = ($urandom_range(0, 9) != 0);
        if ($urandom_range(0, 15) < 14)
          r.issue_class = CLS_W'($urandom_range(0, CLASS_HALT));
        else
          r.issue_class = CLS_W'($urandom_range(CLASS_INVALID, CLASS_RSVD));
        r.dest_reg = ($urandom_range(0, 3) == 0) ? REGF_W'($urandom_range(0, 31))
                                                  : REGF_W'($urandom_range(0, 7));
        r.rob_slot = ($urandom_range(0, 9) == 0) ? SLOT_W'($urandom_range(0, 63))
                                                  : SLOT_W'(next_slot);
        r.src1_reg = ($urandom_range(0, 1) == 0) ? REGF_W'($urandom_range(0, 31))
                                                  : REGF_W'($urandom_range(0, 7));
        r.src2_reg = ($urandom_range(0, 1) == 0) ? REGF_W'($urandom_range(0, 31))
                                                  : REGF_W'($urandom_range(0, 7));
        r.entry_writes_reg = 1'($urandom_range(0, 1));
        if (inflight_q.size() != 0 && $urandom_range(0, 1) == 0) begin
          r.commit_ready = 1'b1;
          r.commit_dest  = inflight_q[0].dest;
          if ($urandom_range(0, 4) != 0) begin
            r.tag_value = inflight_q[0].tag;
            void'(inflight_q.pop_front());
          end else begin
            r.tag_value = tag_t'($urandom_range(0, 64));
          end
        end else begin
          r.commit_ready = ($urandom_range(0, 7) == 0);
          r.commit_dest  = REGF_W'($urandom_range(0, 31));
          r.tag_value    = tag_t'($urandom_range(0, 64));
        end
        take = r.dispatch_ok && (r.issue_class <= CLASS_HALT);
        if (take) begin
          if (inflight_q.size() >= 48) void'(inflight_q.pop_front());
          inflight_q.push_back('{r.dest_reg, tag_t'(int'(r.rob_slot) + 1),
                                 (r.dest_reg != '0) && (r.issue_class != CLASS_BRANCH)
                                 && (r.issue_class != CLASS_STORE)});
          next_slot = (int'(r.rob_slot) + 1) % ROB_DEPTH;
        end
        send_beat(r, 1'b0, '0);
        rand_beats++;
      end
    end
    start <= 1'b0;

    // drain, then watch a little longer for stray strobes
    while (tag_expect_q.size() != 0) @(posedge clk_i);
    repeat (2 * N_REGS + 8) @(posedge clk_i);

    $display("covered %0d accepted beats, %0d results checked in %0d cycles", accepted_cnt,
             checked_cnt, cycle_cnt);
    $display("  %0d squash starts, %0d mapping writes, %0d mismatches", squash_cnt,
             rename_cnt, err_cnt);
    if (err_cnt == 0) begin
      $display("register_rename_table_test: done, clean");
    end else begin
      $display("register_rename_table_test: done, errors");
    end
    $finish;
  end

endmodule
